### rtl/core/cobe_pkg.sv
package cobe_pkg;

  localparam int TIME_W    = 63;
  localparam int OFF_W     = 64;
  localparam int COUNT_W   = 32;
  localparam int ALPHA_W   = 9;
  localparam int BURST_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int PROD_W    = 74;

  localparam int IN_DATA_W  = 192;
  localparam int OUT_DATA_W = 192;
  localparam int OUT_USER_W = 2;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE     = 9'd256;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET   = 9'd64;
  localparam logic [BURST_W-1:0] BURST_RESET   = 4'd5;
  localparam logic [BURST_W-1:0] GOOD_CNT_MAX  = 4'd15;
  localparam logic [COUNT_W-1:0] GOOD_RTT_RESET = 32'd2000;
  localparam logic [OFF_W-1:0]   OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EWMA_ALPHA  = 2'd0,
    CFG_SAMPLES     = 2'd1,
    CFG_GOOD_RTT    = 2'd2
  } cfg_reg_t;

endpackage

### rtl/core/clock_offset_burst_estimator.sv
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: send, recv, remote time; s_tuser: reply_ok
// m_       out  m_tvalid/m_tready  m_tdata: offset, rtt, totals; m_tlast: burst_done;
//                                  m_tuser: applied, first_sync
// cfg_     in   cfg_we             cfg_index selects the register, cfg_data holds the value
//
// One attempt enters per cycle while m_tready does not stall the output register.
// Four stages prepare the sample (input, round trip and midpoint, saturated offset,
// alpha product); the result register closes the burst and blends the offset.
// The loop through the filtered offset is one 9 x 64 multiply and an add per cycle.
// Synchronous reset clears pipeline and estimator state and loads the register defaults.
// A stall on m_tready fills the stages in turn; s_tready drops once all are full.
module clock_offset_burst_estimator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [62:0] send_time_us, [125:63] recv_time_us, [188:126] remote_time_us
  input  logic [cobe_pkg::IN_DATA_W-1:0]     s_tdata,
  // [0] reply_ok
  input  logic                               s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [63:0] filtered offset, [127:64] applied round trip, [159:128] sync_total,
  // [191:160] fail_total
  output logic [cobe_pkg::OUT_DATA_W-1:0]    m_tdata,
  // [0] applied, [1] first_sync
  output logic [cobe_pkg::OUT_USER_W-1:0]    m_tuser,
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [cobe_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cobe_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import cobe_pkg::*;

  // Configuration
  logic [ALPHA_W-1:0]  ewma_alpha;
  logic [BURST_W-1:0]  samples_per_burst;
  logic [COUNT_W-1:0]  good_rtt_us;

  // Pipeline control
  logic v1, v2, v3, v4, vo;
  logic rdy1, rdy2, rdy3, rdy4, adv_o, upd;

  // Stage 1: raw fields
  logic              ok1;
  logic [TIME_W-1:0] send1, recv1, remote1;

  // Stage 2: round trip and offset from midpoint
  logic              good2;
  logic [TIME_W-1:0] rtt2;
  logic signed [OFF_W-1:0] d2;

  // Stage 3: saturated sample offset
  logic              good3, early3;
  logic [TIME_W-1:0] rtt3;
  logic signed [OFF_W-1:0] off3;

  // Stage 4: weighted sample
  logic              good4, early4;
  logic [TIME_W-1:0] rtt4;
  logic signed [OFF_W-1:0]  off4;
  logic signed [PROD_W-1:0] prod4;

  // Estimator state
  logic signed [OFF_W-1:0]  filtered_offset;
  logic                     first_pending;
  logic signed [OFF_W-1:0]  applied_rtt;
  logic [COUNT_W-1:0]       applied_count;
  logic [COUNT_W-1:0]       failed_count;
  logic [TIME_W-1:0]        burst_min_rtt;
  logic signed [OFF_W-1:0]  burst_best_offset;
  logic [BURST_W-1:0]       burst_good_count;
  logic [BURST_W-1:0]       burst_attempt;

  // Result flags
  logic done_o, applied_o, first_o;

  // Combinational values
  logic [TIME_W:0]          time_sum;
  logic [TIME_W-1:0]        mid;
  logic [OFF_W:0]           off_sum;
  logic [ALPHA_W-1:0]       alpha_eff, beta;
  logic                     better, any_good, done, round_up;
  logic [BURST_W-1:0]       attempt_next, limit;
  logic signed [PROD_W-1:0] prod_old, best_prod, sel_prod, blend_sum;
  logic signed [OFF_W-1:0]  sel_off, blend_val;
  logic [TIME_W-1:0]        sel_rtt;

  assign adv_o = !vo || m_tready;
  assign rdy4  = !v4 || adv_o;
  assign rdy3  = !v3 || rdy4;
  assign rdy2  = !v2 || rdy3;
  assign rdy1  = !v1 || rdy2;
  assign s_tready = rdy1;
  assign upd   = v4 && adv_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (adv_o) vo <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ewma_alpha        <= ALPHA_RESET;
      samples_per_burst <= BURST_RESET;
      good_rtt_us       <= GOOD_RTT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EWMA_ALPHA: ewma_alpha        <= cfg_data[ALPHA_W-1:0];
        CFG_SAMPLES:    samples_per_burst <= cfg_data[BURST_W-1:0];
        CFG_GOOD_RTT:   good_rtt_us       <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage 1
  always_ff @(posedge clk) begin
    if (rdy1) begin
      ok1     <= s_tuser;
      send1   <= s_tdata[TIME_W-1:0];
      recv1   <= s_tdata[2*TIME_W-1:TIME_W];
      remote1 <= s_tdata[3*TIME_W-1:2*TIME_W];
    end
  end

  // Stage 2: the midpoint is floored, the sum needs one extra bit.
  always_comb begin
    time_sum = {1'b0, send1} + {1'b0, recv1};
    mid      = time_sum[TIME_W:1];
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      good2 <= ok1 && (recv1 >= send1);
      rtt2  <= recv1 - send1;
      d2    <= $signed({1'b0, remote1}) - $signed({1'b0, mid});
    end
  end

  // Stage 3: add half the round trip and clip at the top of the signed range.
  assign off_sum = {d2[OFF_W-1], d2} + {2'b00, 1'b0, rtt2[TIME_W-1:1]};

  always_ff @(posedge clk) begin
    if (rdy3) begin
      good3  <= good2;
      early3 <= rtt2 < {{(TIME_W-COUNT_W){1'b0}}, good_rtt_us};
      rtt3   <= rtt2;
      off3   <= (!off_sum[OFF_W] && off_sum[OFF_W-1]) ? OFF_MAX : off_sum[OFF_W-1:0];
    end
  end

  // Stage 4
  assign alpha_eff = (ewma_alpha[ALPHA_W-1] && (|ewma_alpha[ALPHA_W-2:0])) ?
                     ALPHA_ONE : ewma_alpha;
  assign beta      = ALPHA_ONE - alpha_eff;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      good4  <= good3;
      early4 <= early3;
      rtt4   <= rtt3;
      off4   <= off3;
      prod4  <= $signed({1'b0, alpha_eff}) * off3;
    end
  end

  // Burst close and blend. The kept sample is weighted with the alpha in force at
  // the close, since alpha may be rewritten between attempts of one burst.
  always_comb begin
    better       = good4 && (rtt4 < burst_min_rtt);
    any_good     = good4 || (burst_good_count != '0);
    attempt_next = burst_attempt + 1'b1;
    limit        = (samples_per_burst == '0) ? {{(BURST_W-1){1'b0}}, 1'b1} : samples_per_burst;
    done         = (good4 && early4) || (attempt_next >= limit);
    best_prod    = $signed({1'b0, alpha_eff}) * burst_best_offset;
    sel_prod     = better ? prod4 : best_prod;
    sel_off      = better ? off4  : burst_best_offset;
    sel_rtt      = better ? rtt4  : burst_min_rtt;
    prod_old     = $signed({1'b0, beta}) * filtered_offset;
    blend_sum    = sel_prod + prod_old;
    // Division by 256 rounds toward zero: bump a negative quotient with a remainder.
    round_up     = blend_sum[PROD_W-1] && (blend_sum[7:0] != 8'd0);
    blend_val    = blend_sum[OFF_W+7:8] + {{(OFF_W-1){1'b0}}, round_up};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filtered_offset   <= '0;
      first_pending     <= 1'b1;
      applied_rtt       <= '1;
      applied_count     <= '0;
      failed_count      <= '0;
      burst_min_rtt     <= '1;
      burst_best_offset <= '0;
      burst_good_count  <= '0;
      burst_attempt     <= '0;
    end else if (upd) begin
      if (done) begin
        if (any_good) begin
          filtered_offset <= first_pending ? sel_off : blend_val;
          first_pending   <= 1'b0;
          applied_rtt     <= {1'b0, sel_rtt};
          applied_count   <= applied_count + 1'b1;
        end else begin
          failed_count <= failed_count + 1'b1;
        end
        burst_min_rtt     <= '1;
        burst_best_offset <= '0;
        burst_good_count  <= '0;
        burst_attempt     <= '0;
      end else begin
        burst_attempt <= attempt_next;
        if (better) begin
          burst_min_rtt     <= rtt4;
          burst_best_offset <= off4;
        end
        if (good4 && (burst_good_count != GOOD_CNT_MAX)) begin
          burst_good_count <= burst_good_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      done_o    <= done;
      applied_o <= done && any_good;
      first_o   <= done && any_good && first_pending;
    end
  end

  // The state only moves when the result register loads, so it matches the held result.
  assign m_tvalid = vo;
  assign m_tlast  = done_o;
  assign m_tuser  = {first_o, applied_o};
  assign m_tdata  = {failed_count, applied_count, applied_rtt, filtered_offset};

`ifndef SYNTH
  a_applied_ends_burst: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser[0] || m_tlast))
    else $error("applied result without burst end");

  a_first_is_applied: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser[1] || m_tuser[0]))
    else $error("first sync without an applied update");

  a_sync_count: assert property (@(posedge clk) disable iff (rst)
    (upd && done && any_good) |=> (applied_count == $past(applied_count) + 1'b1))
    else $error("sync total did not advance on an applied burst");

  a_first_once: assert property (@(posedge clk) disable iff (rst)
    !first_pending |=> !first_pending)
    else $error("first sync became pending again");
`endif

endmodule

### verif/tb_clock_offset_burst_estimator.sv
module tb_clock_offset_burst_estimator;
  timeunit 1ns;
  timeprecision 1ps;

  import cobe_pkg::*;

  localparam logic [TIME_W-1:0] T_MAX = '1;
  localparam int RAND_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 106;
  localparam int HOLD_PHASE = 3;
  localparam int LONG_HOLD = 60;

  typedef struct packed {
    bit              ok;
    logic [TIME_W-1:0] send_us;
    logic [TIME_W-1:0] recv_us;
    logic [TIME_W-1:0] remote_us;
  } attempt_t;

  typedef struct packed {
    bit                 done;
    bit                 applied;
    bit                 first;
    logic [OFF_W-1:0]   offset;
    logic [OFF_W-1:0]   rtt;
    logic [COUNT_W-1:0] syncs;
    logic [COUNT_W-1:0] fails;
  } sync_report_t;

  typedef enum logic [0:0] {STEP_TRY, STEP_SETUP} step_kind_t;

  typedef struct packed {
    step_kind_t              kind;
    cfg_reg_t                sel;
    logic [CFG_DATA_W-1:0]   value;
    attempt_t                try_in;
    bit                      known;
    sync_report_t            want;
  } script_step_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b1;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [OUT_USER_W-1:0]  m_tuser;
  logic                   m_tlast;
  logic                   cfg_we = 1'b0;
  cfg_reg_t               cfg_index = CFG_EWMA_ALPHA;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow copy of the estimator: registers and state.
  logic [ALPHA_W-1:0]        cfg_alpha;
  logic [BURST_W-1:0]        cfg_spb;
  logic [COUNT_W-1:0]        cfg_good;
  logic signed [OFF_W-1:0]   est_offset;
  bit                        first_pending;
  logic signed [OFF_W-1:0]   est_rtt;
  logic [COUNT_W-1:0]        est_syncs;
  logic [COUNT_W-1:0]        est_fails;
  logic [TIME_W-1:0]         min_rtt;
  logic signed [OFF_W-1:0]   best_off;
  logic [BURST_W-1:0]        good_cnt;
  logic [BURST_W-1:0]        attempt_cnt;

  sync_report_t  awaited_reports[$];
  script_step_t  opening_steps[$];

  int unsigned bad_reports = 0;
  int unsigned attempts_sent = 0;
  int unsigned bursts_closed = 0;
  int unsigned bursts_applied = 0;
  int unsigned setups = 0;

  bit          jitter_on = 1'b0;
  bit          hold_kick = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_gap = 0;

  clock_offset_burst_estimator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [TIME_W-1:0] rand63();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TIME_W-1:0];
  endfunction

  // Advances the shadow state by one attempt and returns the result it causes.
  function automatic sync_report_t estimate_report(attempt_t a);
    sync_report_t             r;
    logic [63:0]              rtt;
    logic [63:0]              mid;
    logic signed [65:0]       off_raw;
    logic signed [OFF_W-1:0]  sample;
    logic signed [79:0]       w_new;
    logic signed [79:0]       w_old;
    logic signed [79:0]       mix;
    logic [BURST_W-1:0]       limit;
    bit                       closes;
    closes = 1'b0;
    limit = (cfg_spb == '0) ? 4'd1 : cfg_spb;
    rtt = {1'b0, a.recv_us} - {1'b0, a.send_us};
    if (a.ok && a.recv_us >= a.send_us) begin
      mid = ({1'b0, a.send_us} + {1'b0, a.recv_us}) >> 1;
      off_raw = $signed({3'b000, a.remote_us}) - $signed({2'b00, mid})
                + $signed({2'b00, rtt >> 1});
      sample = (off_raw > $signed({2'b00, OFF_MAX})) ? OFF_MAX : off_raw[OFF_W-1:0];
      if (rtt < {1'b0, min_rtt}) begin
        min_rtt = rtt[TIME_W-1:0];
        best_off = sample;
      end
      if (good_cnt < GOOD_CNT_MAX) good_cnt = good_cnt + 4'd1;
      if (rtt < {32'd0, cfg_good}) closes = 1'b1;
    end
    attempt_cnt = attempt_cnt + 4'd1;
    if (attempt_cnt >= limit) closes = 1'b1;
    r = '0;
    r.done = closes;
    if (closes) begin
      if (good_cnt != '0) begin
        r.applied = 1'b1;
        if (first_pending) begin
          r.first = 1'b1;
          est_offset = best_off;
          first_pending = 1'b0;
        end else begin
          w_new = (cfg_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_alpha;
          w_old = 80'sd256 - w_new;
          // Full-width blend; signed division truncates toward zero.
          mix = (w_new * best_off + w_old * est_offset) / 80'sd256;
          est_offset = mix[OFF_W-1:0];
        end
        est_rtt = {1'b0, min_rtt};
        est_syncs = est_syncs + 1;
      end else begin
        est_fails = est_fails + 1;
      end
      min_rtt = '1;
      best_off = '0;
      good_cnt = '0;
      attempt_cnt = '0;
    end
    r.offset = est_offset;
    r.rtt = est_rtt;
    r.syncs = est_syncs;
    r.fails = est_fails;
    return r;
  endfunction

  function automatic attempt_t draw_attempt();
    attempt_t          a;
    logic [TIME_W-1:0] rtt;
    logic [TIME_W-1:0] d;
    int unsigned       pick;
    pick = $urandom_range(0, 99);
    a.ok = 1'b1;
    a.send_us = rand63();
    a.recv_us = rand63();
    a.remote_us = rand63();
    if (pick < 80) begin
      case ($urandom_range(0, 3))
        0: rtt = $urandom_range(0, 4000);
        1: rtt = $urandom_range(0, 300000);
        2: rtt = $urandom;
        default: rtt = rand63() >> $urandom_range(0, 62);
      endcase
      a.send_us = a.send_us >> $urandom_range(0, 40);
      if (a.send_us > T_MAX - rtt) a.send_us = T_MAX - rtt;
      a.recv_us = a.send_us + rtt;
      d = $urandom_range(0, 2000000);
      case ($urandom_range(0, 3))
        0: a.remote_us = a.remote_us >> $urandom_range(0, 62);
        1: a.remote_us = (a.send_us > T_MAX - d) ? T_MAX : a.send_us + d;
        default: a.remote_us = (a.send_us < d) ? '0 : a.send_us - d;
      endcase
    end else if (pick < 90) begin
      a.ok = 1'b0;
    end else if (pick < 95) begin
      if (a.recv_us >= a.send_us) begin
        d = a.recv_us;
        a.recv_us = a.send_us;
        a.send_us = d;
      end
    end else begin
      a.ok = $urandom_range(0, 1);
    end
    return a;
  endfunction

  function automatic void add_try(bit ok, logic [TIME_W-1:0] send_us,
                                  logic [TIME_W-1:0] recv_us, logic [TIME_W-1:0] remote_us,
                                  bit known = 1'b0, sync_report_t want = '0);
    script_step_t s;
    s = '0;
    s.kind = STEP_TRY;
    s.try_in = {ok, send_us, recv_us, remote_us};
    s.known = known;
    s.want = want;
    opening_steps.push_back(s);
  endfunction

  function automatic void add_setup(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
    script_step_t s;
    s = '0;
    s.kind = STEP_SETUP;
    s.sel = sel;
    s.value = value;
    opening_steps.push_back(s);
  endfunction

  task automatic push_attempt(input attempt_t a, input bit known, input sync_report_t want);
    sync_report_t predicted;
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W-3*TIME_W){1'b0}}, a.remote_us, a.recv_us, a.send_us};
    s_tuser <= a.ok;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = estimate_report(a);
    awaited_reports.push_back(known ? want : predicted);
    attempts_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t sel, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (sel)
      CFG_EWMA_ALPHA: cfg_alpha = value[ALPHA_W-1:0];
      CFG_SAMPLES:    cfg_spb = value[BURST_W-1:0];
      CFG_GOOD_RTT:   cfg_good = value[COUNT_W-1:0];
      default: ;
    endcase
    setups++;
  endtask

  // Receiver side: random back-pressure, plus one long hold on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
    end else if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= LONG_HOLD - 1;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1;
      m_tready <= 1'b0;
    end else if (jitter_on && $urandom_range(0, 5) == 0) begin
      rx_gap <= $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    sync_report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_reports.size() == 0) begin
        bad_reports++;
        if (bad_reports <= 10)
          $display("unexpected result transaction: tdata=%h tuser=%b tlast=%b",
                   m_tdata, m_tuser, m_tlast);
      end else begin
        want = awaited_reports.pop_front();
        bursts_closed += want.done;
        bursts_applied += want.applied;
        if (m_tlast !== want.done || m_tuser[0] !== want.applied ||
            m_tuser[1] !== want.first || m_tdata[63:0] !== want.offset ||
            m_tdata[127:64] !== want.rtt || m_tdata[159:128] !== want.syncs ||
            m_tdata[191:160] !== want.fails) begin
          bad_reports++;
          if (bad_reports <= 10) begin
            $display("mismatch: want done=%b applied=%b first=%b off=%0d rtt=%0d sync=%0d fail=%0d",
                     want.done, want.applied, want.first, $signed(want.offset),
                     $signed(want.rtt), want.syncs, want.fails);
            $display("          got  done=%b applied=%b first=%b off=%0d rtt=%0d sync=%0d fail=%0d",
                     m_tlast, m_tuser[0], m_tuser[1], $signed(m_tdata[63:0]),
                     $signed(m_tdata[127:64]), m_tdata[159:128], m_tdata[191:160]);
          end
        end
      end
    end
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [CFG_DATA_W-1:0] alpha_pick;
    logic [CFG_DATA_W-1:0] spb_pick;
    logic [CFG_DATA_W-1:0] good_pick;
    cfg_alpha = ALPHA_RESET;
    cfg_spb = BURST_RESET;
    cfg_good = GOOD_RTT_RESET;
    est_offset = '0;
    first_pending = 1'b1;
    est_rtt = '1;
    est_syncs = '0;
    est_fails = '0;
    min_rtt = '1;
    best_off = '0;
    good_cnt = '0;
    attempt_cnt = '0;

    // Reset settings: a short round trip closes the burst and loads the offset.
    add_try(1, 1000, 1500, 5000, 1, {3'b111, 64'd4000, 64'd500, 32'd1, 32'd0});
    add_try(0, T_MAX, 0, T_MAX, 1, {3'b000, 64'd4000, 64'd500, 32'd1, 32'd0});
    // A reply stamped before its request is not a good sample.
    add_try(1, 2000, 1000, 7, 1, {3'b000, 64'd4000, 64'd500, 32'd1, 32'd0});
    // The largest round trip is good but never beats the initial best.
    add_try(1, 0, T_MAX, T_MAX, 1, {3'b000, 64'd4000, 64'd500, 32'd1, 32'd0});
    add_try(0, 0, 0, 0, 1, {3'b000, 64'd4000, 64'd500, 32'd1, 32'd0});
    add_try(0, 5, 6, 7, 1, {3'b110, 64'd3000, {1'b0, T_MAX}, 32'd2, 32'd0});
    add_try(1, T_MAX, T_MAX, 0);
    add_setup(CFG_EWMA_ALPHA, 0);
    add_setup(CFG_SAMPLES, 0);
    add_try(0, 12, 34, 56);
    add_try(1, 0, 0, T_MAX);
    // Alpha above one is clamped; burst length cut to two while three attempts are in.
    add_setup(CFG_EWMA_ALPHA, 511);
    add_setup(CFG_SAMPLES, 15);
    add_setup(CFG_GOOD_RTT, 0);
    add_try(1, 5, 9, T_MAX);
    add_try(1, 10, 13, 0);
    add_try(0, 1, 2, 3);
    add_setup(CFG_SAMPLES, 2);
    add_try(0, 4, 5, 6);
    add_setup(CFG_GOOD_RTT, 32'hFFFF_FFFF);
    add_setup(CFG_EWMA_ALPHA, 256);
    add_setup(CFG_SAMPLES, 15);
    add_try(1, 100, 100 + 63'h0_FFFF_FFFE, 123456789);
    add_try(1, 0, 63'h0_FFFF_FFFF, 42);
    add_try(1, T_MAX, T_MAX, T_MAX);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (opening_steps[i]) begin
      if (opening_steps[i].kind == STEP_SETUP) begin
        settle();
        write_reg(opening_steps[i].sel, opening_steps[i].value);
      end else begin
        push_attempt(opening_steps[i].try_in, opening_steps[i].known, opening_steps[i].want);
      end
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 4))
        0: alpha_pick = 0;
        1: alpha_pick = 256;
        2: alpha_pick = 511;
        default: alpha_pick = $urandom_range(0, 256);
      endcase
      case ($urandom_range(0, 4))
        0: spb_pick = 0;
        1: spb_pick = 1;
        2: spb_pick = 15;
        default: spb_pick = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 4))
        0: good_pick = 0;
        1: good_pick = 32'hFFFF_FFFF;
        2: good_pick = $urandom;
        default: good_pick = $urandom_range(0, 5000);
      endcase
      // Long bursts with no early close drive the good count high; a burst closes before it saturates.
      if (ph == 0) begin
        spb_pick = 15;
        good_pick = 0;
      end
      jitter_on <= (ph % 3 != 2) && (ph != HOLD_PHASE) && (ph < RAND_PHASES - 1);
      settle();
      write_reg(CFG_EWMA_ALPHA, alpha_pick);
      write_reg(CFG_SAMPLES, spb_pick);
      write_reg(CFG_GOOD_RTT, good_pick);
      if (ph == HOLD_PHASE) hold_kick <= ~hold_kick;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (jitter_on && $urandom_range(0, 4) == 0) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        push_attempt(draw_attempt(), 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Sent %0d attempts under %0d register writes, including one long output stall.",
             attempts_sent, setups);
    $display("Bursts closed: %0d, with an offset update: %0d; bad results: %0d.",
             bursts_closed, bursts_applied, bad_reports);
    if (bad_reports == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
